// ===== rtl/core/directional_cursor_target_select_defines.svh =====
// Assertion macros used by the cursor target select top module.
`ifndef DIRECTIONAL_CURSOR_TARGET_SELECT_DEFINES_SVH
`define DIRECTIONAL_CURSOR_TARGET_SELECT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DCTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcts: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DCTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcts: next-cycle check failed");

`endif

// ===== rtl/core/dcts_pkg.sv =====
package dcts_pkg;

    // Squares per board side; coordinates at or above this count as off the board
    localparam int BOARD_SIZE = 8;
    localparam int COORD_W    = 3;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // One candidate item as held in the input register
    typedef struct packed {
        coord_t cell_row;
        coord_t cell_col;
        logic   cell_valid;
        coord_t here_row;
        coord_t here_col;
        logic   here_valid;
        dir_t   move_dir;
        logic   last;
    } item_t;

    // Outcome of a run, as seen on the last item
    typedef struct packed {
        logic   found;
        coord_t next_row;
        coord_t next_col;
    } result_t;

endpackage

// ===== rtl/core/dcts_in_stage.sv =====
module dcts_in_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [dcts_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tlast,
    input  logic                                 advance,
    output logic                                 item_valid,
    output dcts_pkg::item_t                      item
);

    logic            valid_reg;
    logic            valid_next;
    dcts_pkg::item_t item_reg;
    dcts_pkg::item_t item_next;
    logic            load;

    // Take a new item when the register is empty or drains this cycle
    assign s_axis_tready = !valid_reg || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    // Unpack the bus word into fields
    always_comb
    begin
        item_next.cell_row   = s_axis_tdata[2:0];
        item_next.cell_col   = s_axis_tdata[5:3];
        item_next.cell_valid = s_axis_tdata[6];
        item_next.here_row   = s_axis_tdata[9:7];
        item_next.here_col   = s_axis_tdata[12:10];
        item_next.here_valid = s_axis_tdata[13];
        item_next.move_dir   = dcts_pkg::dir_t'(s_axis_tdata[15:14]);
        item_next.last       = s_axis_tlast;
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/dcts_track.sv =====
module dcts_track
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dcts_pkg::item_t   item,
    output dcts_pkg::result_t result
);

    typedef logic [4*dcts_pkg::COORD_W-1:0] key_t;

    logic                in_run_reg,      in_run_next;
    dcts_pkg::coord_t    here_row_reg,    here_row_next;
    dcts_pkg::coord_t    here_col_reg,    here_col_next;
    logic                here_ok_reg,     here_ok_next;
    dcts_pkg::dir_t      dir_reg,         dir_next;
    logic                ahead_found_reg, ahead_found_next;
    dcts_pkg::coord_t    ahead_row_reg,   ahead_row_next;
    dcts_pkg::coord_t    ahead_col_reg,   ahead_col_next;
    logic                wrap_found_reg,  wrap_found_next;
    dcts_pkg::coord_t    wrap_row_reg,    wrap_row_next;
    dcts_pkg::coord_t    wrap_col_reg,    wrap_col_next;
    logic                saw_reg,         saw_next;

    logic                first;
    logic                cell_ok;
    logic                is_here;
    logic                considered;
    logic                ahead;
    logic                a_found;
    logic                w_found;
    dcts_pkg::coord_t    a_row;
    dcts_pkg::coord_t    a_col;
    dcts_pkg::coord_t    w_row;
    dcts_pkg::coord_t    w_col;
    logic                take_ahead;
    logic                take_wrap;

    function automatic dcts_pkg::coord_t absdiff(dcts_pkg::coord_t a, dcts_pkg::coord_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic on_board(dcts_pkg::coord_t r, dcts_pkg::coord_t c);
        return (int'(r) < dcts_pkg::BOARD_SIZE) && (int'(c) < dcts_pkg::BOARD_SIZE);
    endfunction

    function automatic logic is_vertical(dcts_pkg::dir_t d);
        return (d == dcts_pkg::DIR_UP) || (d == dcts_pkg::DIR_DOWN);
    endfunction

    // Perpendicular offset, forward distance, row, column; lower wins
    function automatic key_t ahead_key(dcts_pkg::coord_t r, dcts_pkg::coord_t c,
                                       dcts_pkg::coord_t hr, dcts_pkg::coord_t hc,
                                       dcts_pkg::dir_t d);
        dcts_pkg::coord_t dr;
        dcts_pkg::coord_t dc;
        dr = absdiff(r, hr);
        dc = absdiff(c, hc);
        return is_vertical(d) ? {dc, dr, r, c} : {dr, dc, r, c};
    endfunction

    // Edge coordinate (inverted for up and left), perpendicular offset, row, column
    function automatic key_t wrap_key(dcts_pkg::coord_t r, dcts_pkg::coord_t c,
                                      dcts_pkg::coord_t hr, dcts_pkg::coord_t hc,
                                      dcts_pkg::dir_t d);
        dcts_pkg::coord_t e;
        dcts_pkg::coord_t p;
        unique case (d)
            dcts_pkg::DIR_UP:    e = ~r;
            dcts_pkg::DIR_DOWN:  e = r;
            dcts_pkg::DIR_LEFT:  e = ~c;
            dcts_pkg::DIR_RIGHT: e = c;
            default:             e = c;
        endcase
        p = is_vertical(d) ? absdiff(c, hc) : absdiff(r, hr);
        return {e, p, r, c};
    endfunction

    // Latch the current square and direction on the first item of a run
    always_comb
    begin
        first         = !in_run_reg;
        here_row_next = first ? item.here_row : here_row_reg;
        here_col_next = first ? item.here_col : here_col_reg;
        here_ok_next  = first ? (item.here_valid && on_board(item.here_row, item.here_col))
                              : here_ok_reg;
        dir_next      = first ? item.move_dir : dir_reg;
        a_found       = first ? 1'b0 : ahead_found_reg;
        w_found       = first ? 1'b0 : wrap_found_reg;
        a_row         = ahead_row_reg;
        a_col         = ahead_col_reg;
        w_row         = wrap_row_reg;
        w_col         = wrap_col_reg;
    end

    // Classify the candidate against the current square
    always_comb
    begin
        cell_ok    = item.cell_valid && on_board(item.cell_row, item.cell_col);
        is_here    = (item.cell_row == here_row_next) && (item.cell_col == here_col_next);
        considered = cell_ok && here_ok_next && !is_here;
        unique case (dir_next)
            dcts_pkg::DIR_UP:    ahead = item.cell_row < here_row_next;
            dcts_pkg::DIR_DOWN:  ahead = item.cell_row > here_row_next;
            dcts_pkg::DIR_LEFT:  ahead = item.cell_col < here_col_next;
            dcts_pkg::DIR_RIGHT: ahead = item.cell_col > here_col_next;
            default:             ahead = 1'b0;
        endcase
    end

    // Update the forward and wrap-around best trackers
    always_comb
    begin
        take_ahead = considered && ahead &&
            (!a_found ||
             (ahead_key(item.cell_row, item.cell_col, here_row_next, here_col_next, dir_next) <
              ahead_key(a_row, a_col, here_row_next, here_col_next, dir_next)));
        take_wrap = considered &&
            (!w_found ||
             (wrap_key(item.cell_row, item.cell_col, here_row_next, here_col_next, dir_next) <
              wrap_key(w_row, w_col, here_row_next, here_col_next, dir_next)));

        ahead_found_next = a_found || take_ahead;
        ahead_row_next   = take_ahead ? item.cell_row : a_row;
        ahead_col_next   = take_ahead ? item.cell_col : a_col;
        wrap_found_next  = w_found || take_wrap;
        wrap_row_next    = take_wrap ? item.cell_row : w_row;
        wrap_col_next    = take_wrap ? item.cell_col : w_col;
        saw_next         = (first ? 1'b0 : saw_reg) || (cell_ok && here_ok_next && is_here);
        in_run_next      = !item.last;
    end

    // Pick the destination: forward first, then wrap, then stay put if the current square was listed, else none
    always_comb
    begin
        result = '0;
        priority if (!here_ok_next)
        begin
            result = '0;
        end
        else if (ahead_found_next)
        begin
            result.found    = 1'b1;
            result.next_row = ahead_row_next;
            result.next_col = ahead_col_next;
        end
        else if (wrap_found_next)
        begin
            result.found    = 1'b1;
            result.next_row = wrap_row_next;
            result.next_col = wrap_col_next;
        end
        else if (saw_next)
        begin
            result.found    = 1'b1;
            result.next_row = here_row_next;
            result.next_col = here_col_next;
        end
        else
        begin
            result = '0;
        end
    end

    // Hold run control and found flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg      <= 1'b0;
            here_ok_reg     <= 1'b0;
            dir_reg         <= dcts_pkg::DIR_UP;
            ahead_found_reg <= 1'b0;
            wrap_found_reg  <= 1'b0;
            saw_reg         <= 1'b0;
        end
        else if (step)
        begin
            in_run_reg      <= in_run_next;
            here_ok_reg     <= here_ok_next;
            dir_reg         <= dir_next;
            ahead_found_reg <= ahead_found_next;
            wrap_found_reg  <= wrap_found_next;
            saw_reg         <= saw_next;
        end
    end

    // Advance the coordinate payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            here_row_reg  <= here_row_next;
            here_col_reg  <= here_col_next;
            ahead_row_reg <= ahead_row_next;
            ahead_col_reg <= ahead_col_next;
            wrap_row_reg  <= wrap_row_next;
            wrap_col_reg  <= wrap_col_next;
        end
    end

endmodule

// ===== rtl/core/directional_cursor_target_select.sv =====
// Channel  | Dir | Handshake                        | Payload
// s_axis   | in  | tvalid/tready, tlast ends a run  | one candidate square per item
// m_axis   | out | tvalid/tready                    | one result per run
//
// One candidate item is accepted per cycle while the result side keeps up.
// Each item waits in the input register, where the tracker update runs; the
// result of a run lands in the output register at the edge where its last item
// leaves the input register.
// rst_n clears the run state and both valid flags asynchronously.
// A held result stalls the input register only, and s_axis_tready drops once it is full.
`include "directional_cursor_target_select_defines.svh"

module directional_cursor_target_select
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] cell_row, [5:3] cell_col, [6] cell_valid, [9:7] here_row,
    // [12:10] here_col, [13] here_valid, [15:14] move_dir
    input  logic [dcts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] found, [3:1] next_row, [6:4] next_col, [7] zero
    output logic [dcts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic              advance;
    logic              item_valid;
    dcts_pkg::item_t   item;
    dcts_pkg::result_t result;
    logic              step;

    logic              out_valid_reg, out_valid_next;
    dcts_pkg::result_t out_reg,       out_next;

    // Drain the input register whenever the output register is free or taken
    assign advance = !out_valid_reg || m_axis_tready;
    assign step    = item_valid && advance;

    dcts_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    dcts_track u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    // Load the tracker result while draining; it is valid when the last item of a run goes through
    always_comb
    begin
        out_next = out_reg;
        if (advance)
        begin
            out_valid_next = step && item.last;
            out_next       = result;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.next_col, out_reg.next_row, out_reg.found};

    // A result without a destination carries zero coordinates
    `DCTS_ASSERT_IMP(a_notfound_zero, clk, rst_n, out_valid_reg && !out_reg.found, out_reg.next_row == '0 && out_reg.next_col == '0)
    // Back-pressure only when an item is already held
    `DCTS_ASSERT_IMP(a_ready_full, clk, rst_n, !s_axis_tready, item_valid && out_valid_reg && !m_axis_tready)
    // A last item leaving the input register always yields a result
    `DCTS_ASSERT_NXT(a_last_result, clk, rst_n, step && item.last, out_valid_reg)

endmodule
